// ----- src/url_query_pair_splitter_macros.svh -----
// Assertion helpers shared by the RTL of the query splitter.
`ifndef URL_QUERY_PAIR_SPLITTER_MACROS_SVH
`define URL_QUERY_PAIR_SPLITTER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define UQPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define UQPS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- src/uqps_pkg.sv -----
package uqps_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_PAIR  = 2'd1;
    localparam logic [1:0] KIND_QEND  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // Characters with a meaning in the query syntax.
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_EQUAL    = 8'h3D;
    localparam logic [7:0] CH_AMP      = 8'h26;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_PERCENT  = 8'h25;
    localparam logic [7:0] CH_SPACE    = 8'h20;

    // Depth of the result queue; a power of two with at least two entries, since the
    // queue pointers wrap at their natural width.
    localparam int unsigned QUEUE_DEPTH = 4;

    // Register map.
    localparam logic SEEK_REG_INDEX = 1'b0;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       in_value;
        logic [1:0] kind;
        logic       value_present;
        logic       last;
    } result_t;

    // Hex digit decode: bit 4 set means the byte is not a hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        begin
            r = 5'h10;
            if (b >= 8'h30 && b <= 8'h39)
            begin
                r = {1'b0, 4'(b - 8'h30)};
            end
            else if (b >= 8'h41 && b <= 8'h46)
            begin
                r = {1'b0, 4'(b - 8'h37)};
            end
            else if (b >= 8'h61 && b <= 8'h66)
            begin
                r = {1'b0, 4'(b - 8'h57)};
            end
            return r;
        end
    endfunction

endpackage

// ----- src/url_query_pair_splitter.sv -----
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: data_byte; s_tuser: string_start
// m_*       out  m_tvalid/m_tready  m_tdata: out_byte, in_value, value_present;
//                                   m_tuser: kind; m_tlast: last
// APB       in   psel/penable       register 0 at address 0: seek_question_mark
//
// An item is taken into the input register and decoded there once two queue slots are free,
// which pushes its zero, one or two results into a four-entry result queue; the first result
// is offered on m_tvalid from the queue, so it passes the input register and then the result
// queue. One item is taken per cycle while the queue has room for two results; items that
// cause two results can therefore back the input up when the output drains at one per cycle.
// Reset clears the parser to the seek phase, sets seek_question_mark and empties the queue.
// Back pressure on m_tready fills the queue and then holds the input register.
`include "url_query_pair_splitter_macros.svh"

module url_query_pair_splitter (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] string_start
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [8] in_value, [9] value_present
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned QueueDepth = uqps_pkg::QUEUE_DEPTH;
    localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int unsigned CntW = $clog2(QueueDepth + 1);

    typedef enum logic [2:0] {
        PH_SEEK,
        PH_PAIR,
        PH_KEY,
        PH_VALUE,
        PH_DONE,
        PH_HALT
    } phase_t;

    // Registers.
    logic                seek_reg;
    phase_t              phase_reg, phase_next;
    logic [1:0]          esc_cnt_reg, esc_cnt_next;
    logic [3:0]          esc_hi_reg, esc_hi_next;
    logic                vseen_reg, vseen_next;
    logic                in_vld_reg;
    logic [7:0]          in_byte_reg;
    logic                in_start_reg;
    uqps_pkg::result_t   queue_reg [QueueDepth];
    logic [PtrW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]     count_reg, count_next;

    // Decode signals.
    uqps_pkg::result_t   res0, res1;
    logic [1:0]          nres;
    logic                fire;
    logic                pop;
    logic                cfg_write;

    // Configuration access.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == uqps_pkg::SEEK_REG_INDEX) ? {31'b0, seek_reg} : 32'b0;

    // Queue handshakes; an item is decoded only when two queue slots are free.
    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign fire     = in_vld_reg && (count_reg <= CntW'(QueueDepth - 2));
    assign s_tready = !in_vld_reg || fire;

    // Result output from the head of the queue.
    assign m_tdata = {6'b0, queue_reg[rd_ptr_reg].value_present,
                      queue_reg[rd_ptr_reg].in_value, queue_reg[rd_ptr_reg].out_byte};
    assign m_tuser = queue_reg[rd_ptr_reg].kind;
    assign m_tlast = queue_reg[rd_ptr_reg].last;

    // Parser: one raw byte in, up to two results and the next parser state out.
    always_comb
    begin
        phase_t     ph;
        logic [4:0] hex;
        logic       blank;
        logic       skip;
        logic       seg;
        logic       seg_val;
        ph           = in_start_reg ? PH_SEEK : phase_reg;
        phase_next   = ph;
        esc_cnt_next = in_start_reg ? 2'd0 : esc_cnt_reg;
        esc_hi_next  = in_start_reg ? 4'd0 : esc_hi_reg;
        vseen_next   = in_start_reg ? 1'b0 : vseen_reg;
        hex          = uqps_pkg::hex_digit(in_byte_reg);
        blank        = (in_byte_reg <= uqps_pkg::CH_SPACE);
        skip         = 1'b0;
        seg          = 1'b0;
        seg_val      = 1'b0;
        res0         = '0;
        res1         = '0;
        nres         = 2'd0;

        if (ph == PH_DONE || ph == PH_HALT)
        begin
            nres = 2'd0;
        end
        else if (esc_cnt_next != 2'd0)
        begin
            // Inside an escape: collect two hex digits.
            if (hex[4])
            begin
                phase_next   = PH_HALT;
                esc_cnt_next = 2'd0;
                res0.kind    = uqps_pkg::KIND_ERROR;
                nres         = 2'd1;
            end
            else if (esc_cnt_next == 2'd1)
            begin
                esc_hi_next  = hex[3:0];
                esc_cnt_next = 2'd2;
            end
            else
            begin
                esc_cnt_next  = 2'd0;
                res0.out_byte = {esc_hi_next, hex[3:0]};
                res0.in_value = (ph == PH_VALUE);
                res0.kind     = uqps_pkg::KIND_DATA;
                nres          = 2'd1;
            end
        end
        else
        begin
            // Find the start of the query.
            if (ph == PH_SEEK)
            begin
                skip = 1'b1;
                if (seek_reg)
                begin
                    if (in_byte_reg == uqps_pkg::CH_QUESTION)
                    begin
                        phase_next = PH_PAIR;
                    end
                end
                else if (!blank)
                begin
                    skip       = 1'b0;
                    ph         = PH_PAIR;
                    phase_next = PH_PAIR;
                end
            end

            if (!skip)
            begin
                unique case (ph)
                    PH_PAIR:
                    begin
                        if (blank)
                        begin
                            phase_next = PH_DONE;
                            res0.kind  = uqps_pkg::KIND_QEND;
                            nres       = 2'd1;
                        end
                        else
                        begin
                            vseen_next = 1'b0;
                            phase_next = PH_KEY;
                            seg        = 1'b1;
                        end
                    end
                    PH_KEY, PH_VALUE:
                    begin
                        if (blank)
                        begin
                            phase_next         = PH_DONE;
                            res0.kind          = uqps_pkg::KIND_PAIR;
                            res0.value_present = vseen_next;
                            res1.kind          = uqps_pkg::KIND_QEND;
                            nres               = 2'd2;
                        end
                        else if (ph == PH_KEY && in_byte_reg == uqps_pkg::CH_EQUAL)
                        begin
                            phase_next = PH_VALUE;
                        end
                        else if (ph == PH_VALUE && in_byte_reg == uqps_pkg::CH_AMP)
                        begin
                            phase_next         = PH_PAIR;
                            res0.kind          = uqps_pkg::KIND_PAIR;
                            res0.value_present = vseen_next;
                            nres               = 2'd1;
                        end
                        else
                        begin
                            seg     = 1'b1;
                            seg_val = (ph == PH_VALUE);
                            if (ph == PH_VALUE)
                            begin
                                vseen_next = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        nres = 2'd0;
                    end
                endcase
            end

            // One raw byte of a key or value.
            if (seg)
            begin
                if (in_byte_reg == uqps_pkg::CH_PERCENT)
                begin
                    esc_cnt_next = 2'd1;
                end
                else
                begin
                    res0.out_byte = (in_byte_reg == uqps_pkg::CH_PLUS) ?
                                    uqps_pkg::CH_SPACE : in_byte_reg;
                    res0.in_value = seg_val;
                    res0.kind     = uqps_pkg::KIND_DATA;
                    nres          = 2'd1;
                end
            end
        end

        // Mark the final result of this item.
        if (nres == 2'd2)
        begin
            res1.last = 1'b1;
        end
        else if (nres == 2'd1)
        begin
            res0.last = 1'b1;
        end
    end

    // Queue occupancy after this cycle's push and pop.
    always_comb
    begin
        count_next = count_reg + (fire ? CntW'(nres) : CntW'(0)) - CntW'(pop);
    end

    // Control state, parser state and register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seek_reg    <= 1'b1;
            phase_reg   <= PH_SEEK;
            esc_cnt_reg <= 2'd0;
            esc_hi_reg  <= 4'd0;
            vseen_reg   <= 1'b0;
            in_vld_reg  <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
        end
        else
        begin
            if (cfg_write && paddr[2] == uqps_pkg::SEEK_REG_INDEX)
            begin
                seek_reg <= pwdata[0];
            end
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            if (fire)
            begin
                phase_reg   <= phase_next;
                esc_cnt_reg <= esc_cnt_next;
                esc_hi_reg  <= esc_hi_next;
                vseen_reg   <= vseen_next;
                wr_ptr_reg  <= wr_ptr_reg + PtrW'(nres);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            end
            count_reg <= count_next;
        end
    end

    // Input payload register.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (fire && nres != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (fire && nres == 2'd2)
        begin
            queue_reg[wr_ptr_reg + PtrW'(1)] <= res1;
        end
    end

    // Checks on the queue and the parser state.
    `UQPS_NEVER(a_queue_overflow, count_reg > CntW'(QueueDepth), "result queue overflow")
    `UQPS_NEVER(a_pop_when_empty, pop && count_reg == '0, "pop from empty result queue")
    `UQPS_ASSERT(a_escape_phase, (esc_cnt_reg != 2'd0) |-> (phase_reg == PH_KEY || phase_reg == PH_VALUE), "escape outside key or value")
    `UQPS_ASSERT(a_stopped_silent, (fire && !in_start_reg && (phase_reg == PH_DONE || phase_reg == PH_HALT)) |-> (nres == 2'd0), "result after query end")

endmodule
